// ===== hw/rtl/shab_pkg.sv =====
// Package for the SHA-256 byte stream hasher: payload structs, FSM state,
// round constants, initial hash values and round functions. No dependencies.
package shab_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
        logic [31:0] digest_word5;
        logic [31:0] digest_word6;
        logic [31:0] digest_word7;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_FIN,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       load_byte;   // write byte at fill, advance fill and bit count
        logic       write_pad;   // write pad byte (0x80 on first, 0 after) at fill
        logic       write_len;   // write length byte at fill
        logic       start_comp;  // load working vars, start 64 rounds
        logic       round;       // do one round
        logic       finish_comp; // add working vars into hash words
        logic       reset_msg;   // restore initial state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [5:0] fill;
        logic       last_round;
        logic       pad_first;   // next pad byte is 0x80
    } t_status;

    localparam int BlockBytes = 64;
    localparam int Rounds     = 64;
    localparam logic [7:0] PadMark = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== hw/rtl/shab_datapath.sv =====
// Datapath of the SHA-256 hasher: block buffer as 16 message words in a
// shift window, fill and bit counters, hash and working registers. Uses shab_pkg.
module shab_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shab_pkg::t_cmd    i_cmd,
    input  logic [7:0]        i_data_byte,
    output shab_pkg::t_status o_status,
    output logic [31:0]       o_hash [8]
);
    import shab_pkg::*;

    // 16-word schedule window; word 0 is the oldest. Bytes are written into it
    // big-endian while filling, then it rotates through the schedule.
    logic [31:0] r_w [16];
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [5:0]  r_round;
    logic        r_pad_first;

    logic [7:0]  wr_byte;
    logic        wr_en;
    logic [3:0]  wr_word;
    logic [1:0]  wr_lane;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_next;
    logic [2:0]  len_idx;

    assign len_idx = r_fill[2:0];
    assign wr_word = r_fill[5:2];
    assign wr_lane = r_fill[1:0];
    assign wr_en   = i_cmd.load_byte | i_cmd.write_pad | i_cmd.write_len;

    always_comb begin
        wr_byte = i_data_byte;
        if (i_cmd.write_pad) begin
            wr_byte = r_pad_first ? PadMark : 8'h00;
        end else if (i_cmd.write_len) begin
            wr_byte = r_bits[63 - {len_idx, 3'b000} -: 8];
        end
    end

    assign t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + RoundK[r_round] + r_w[0];
    assign t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_next = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_w[wr_word][31 - {wr_lane, 3'b000} -: 8] <= wr_byte;
        end else if (i_cmd.round) begin
            for (int k = 0; k < 15; k++) begin
                r_w[k] <= r_w[k + 1];
            end
            r_w[15] <= w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_comp) begin
            r_v <= r_h;
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reset_msg) begin
            r_h         <= InitH;
            r_fill      <= '0;
            r_bits      <= '0;
            r_round     <= '0;
            r_pad_first <= 1'b1;
        end else begin
            if (wr_en) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.load_byte) begin
                r_bits <= r_bits + 64'd8;
            end
            if (i_cmd.write_pad) begin
                r_pad_first <= 1'b0;
            end
            if (i_cmd.start_comp) begin
                r_round <= '0;
            end else if (i_cmd.round) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.finish_comp) begin
                for (int k = 0; k < 8; k++) begin
                    r_h[k] <= r_h[k] + r_v[k];
                end
            end
        end
    end

    assign o_status.fill       = r_fill;
    assign o_status.last_round = (r_round == 6'(Rounds - 1));
    assign o_status.pad_first  = r_pad_first;
    assign o_hash = r_h;

endmodule

// ===== hw/rtl/shab_controller.sv =====
// Controller of the SHA-256 hasher: input/output handshakes and the
// sequence of byte loads, padding, length and compressions. Uses shab_pkg.
module shab_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  shab_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    input  shab_pkg::t_status i_status,
    output shab_pkg::t_cmd    o_cmd
);
    import shab_pkg::*;

    t_state r_state, n_state;
    logic   r_closing;   // end of message pending after current compression
    logic   n_closing;
    logic   r_len_phase; // final block: length bytes being written
    logic   n_len_phase;
    logic   accept;

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_closing   <= 1'b0;
            r_len_phase <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_closing   <= n_closing;
            r_len_phase <= n_len_phase;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_closing   = r_closing;
        n_len_phase = r_len_phase;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_closing = i_item.end_of_message;
                    if (i_item.byte_present && i_status.fill == 6'd63) begin
                        n_state = ST_COMP;
                    end else if (i_item.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_COMP: begin
                if (i_status.last_round) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (r_len_phase) begin
                    n_state = ST_OUT;
                end else if (r_closing) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                // pad up to 56, or to 64 then compress and pad again
                if (i_status.fill == 6'd63) begin
                    n_state = ST_COMP;
                end else if (i_status.fill == LenStart - 6'd1) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (i_status.fill == 6'd63) begin
                    n_state     = ST_COMP;
                    n_len_phase = 1'b1;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state     = ST_IDLE;
                    n_closing   = 1'b0;
                    n_len_phase = 1'b0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                o_cmd.load_byte = accept && i_item.byte_present;
            end
            ST_COMP: begin
                o_cmd.round = 1'b1;
            end
            ST_FIN: begin
                o_cmd.finish_comp = 1'b1;
            end
            ST_PAD: begin
                o_cmd.write_pad  = 1'b1;
                o_cmd.start_comp = (i_status.fill == 6'd63);
            end
            ST_LEN: begin
                o_cmd.write_len  = 1'b1;
                o_cmd.start_comp = (i_status.fill == 6'd63);
            end
            ST_OUT: begin
                o_valid         = 1'b1;
                o_cmd.reset_msg = i_ready;
            end
            default: ;
        endcase
        if (r_state == ST_IDLE && accept && i_item.byte_present && i_status.fill == 6'd63) begin
            o_cmd.start_comp = 1'b1;
        end
    end

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("ready while busy");
    a_len_at_56: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD && $past(r_state) == ST_PAD && n_state == ST_LEN)
        |-> (i_status.fill == LenStart - 6'd1)) else $error("length misplaced");
    a_out_after_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == ST_FIN) else $error("digest without compression");

endmodule

// ===== hw/rtl/sha256_byte_stream_hasher_core.sv =====
// Top level of the SHA-256 byte stream hasher: joins controller and datapath.
// Depends on shab_pkg, shab_controller, shab_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  in       | i_valid / o_ready    | i_item  (data_byte, byte_present, eom)
//  out      | o_valid / i_ready    | o_item  (digest_word0..digest_word7)
//
// A byte that neither completes a block nor ends the message leaves the core ready
// for the next byte. A byte that fills the block starts a compression: 64 rounds,
// one round per cycle, then the working words are added into the hash words.
// Closing writes pad and length bytes one per cycle into the block buffer
// (its single write port sets this), then compresses each final block the
// same way before the digest is offered.
// Reset is synchronous, active low; the hash words return to initial values.
// The digest holds on o_item while o_valid waits for i_ready; no input is
// taken until it is transferred.
module sha256_byte_stream_hasher_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  shab_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output shab_pkg::t_out_item  o_item
);
    import shab_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic [31:0] hash [8];

    shab_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    shab_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_item.data_byte),
        .o_status    (status),
        .o_hash      (hash)
    );

    // hash registers hold steady while the digest is offered
    assign o_item.digest_word0 = hash[0];
    assign o_item.digest_word1 = hash[1];
    assign o_item.digest_word2 = hash[2];
    assign o_item.digest_word3 = hash[3];
    assign o_item.digest_word4 = hash[4];
    assign o_item.digest_word5 = hash[5];
    assign o_item.digest_word6 = hash[6];
    assign o_item.digest_word7 = hash[7];

endmodule
